// ===== src/sat3_pkg.sv =====
// Shared types, constants and the literal decoder for the 3-SAT solver.
// No dependencies.
package sat3_pkg;

  localparam int MAX_VARS_DEF    = 20;
  localparam int MAX_CLAUSES_DEF = 256;
  localparam int LIT_W           = 6;
  localparam int CLAUSE_W        = 3 * LIT_W;
  localparam int VC_W            = 5;
  localparam int STATUS_W        = 2;
  localparam int OUT_TDATA_W     = 8;
  localparam int IN_TDATA_W      = 24;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SOLVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UNSAT    = 2'd0,
    ST_SAT      = 2'd1,
    ST_BADVARS  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    clr_search;
    logic    next_clause;
    logic    next_assign;
    logic    set_status;
    status_t status;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic overflow;
    logic vars_bad;
    logic empty;
    logic clause_true;
    logic last_clause;
    logic last_assign;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic            hit;
    logic            neg;
    logic [VC_W-1:0] idx;
  } lit_t;

  // Variable v sits in assignment bit v-1; zero or out-of-range literals never hit.
  function automatic lit_t lit_decode(logic [LIT_W-1:0] lit, logic [VC_W-1:0] nv);
    lit_t            d;
    logic [LIT_W-1:0] mag;
    mag   = lit[LIT_W-1] ? (~lit + LIT_W'(1)) : lit;
    d.hit = (mag != '0) && (mag <= {1'b0, nv});
    d.neg = lit[LIT_W-1];
    d.idx = VC_W'(mag - LIT_W'(1));
    return d;
  endfunction

endpackage

// ===== src/sat3_ctrl.sv =====
// Sequencer for clause loads and the exhaustive assignment search.
// Depends on sat3_pkg; drives sat3_dp through cmd_t and reads sts_t.
module sat3_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_op,
  input  sat3_pkg::sts_t sts,
  output sat3_pkg::cmd_t cmd
);

  sat3_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sat3_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = sat3_pkg::ST_UNSAT;
    in_tready = 1'b0;
    unique case (state_r)
      sat3_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == sat3_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (sts.overflow) begin
            cmd.set_status = 1'b1;
            cmd.status     = sat3_pkg::ST_OVERFLOW;
            state_nxt      = sat3_pkg::S_DONE;
          end else if (sts.vars_bad) begin
            cmd.set_status = 1'b1;
            cmd.status     = sat3_pkg::ST_BADVARS;
            state_nxt      = sat3_pkg::S_DONE;
          end else if (sts.empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = sat3_pkg::ST_SAT;
            state_nxt      = sat3_pkg::S_DONE;
          end else begin
            cmd.clr_search = 1'b1;
            state_nxt      = sat3_pkg::S_FETCH;
          end
        end
      end
      sat3_pkg::S_FETCH: begin
        state_nxt = sat3_pkg::S_CHECK;
      end
      sat3_pkg::S_CHECK: begin
        if (sts.clause_true) begin
          if (sts.last_clause) begin
            cmd.set_status = 1'b1;
            cmd.status     = sat3_pkg::ST_SAT;
            state_nxt      = sat3_pkg::S_DONE;
          end else begin
            cmd.next_clause = 1'b1;
            state_nxt       = sat3_pkg::S_FETCH;
          end
        end else if (sts.last_assign) begin
          cmd.set_status = 1'b1;
          cmd.status     = sat3_pkg::ST_UNSAT;
          state_nxt      = sat3_pkg::S_DONE;
        end else begin
          cmd.next_assign = 1'b1;
          state_nxt       = sat3_pkg::S_FETCH;
        end
      end
      sat3_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = sat3_pkg::S_IDLE;
        end
      end
      default: state_nxt = sat3_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/sat3_dp.sv =====
// Datapath: clause memory, counters, clause evaluator and output register.
// Depends on sat3_pkg; commanded by sat3_ctrl.
module sat3_dp #(
  parameter int MAX_VARS    = sat3_pkg::MAX_VARS_DEF,
  parameter int MAX_CLAUSES = sat3_pkg::MAX_CLAUSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sat3_pkg::VC_W-1:0]        cfg_wdata,
  input  logic [sat3_pkg::CLAUSE_W-1:0]    in_clause,
  input  sat3_pkg::cmd_t                   cmd,
  output sat3_pkg::sts_t                   sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sat3_pkg::STATUS_W-1:0]    out_status
);

  localparam int AD = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
  localparam int CW = $clog2(MAX_CLAUSES + 1);
  localparam int AW = MAX_VARS;
  localparam logic [CW-1:0]                MaxCl   = CW'(MAX_CLAUSES);
  localparam logic [sat3_pkg::VC_W-1:0]    MaxVarW = sat3_pkg::VC_W'(MAX_VARS);

  logic [sat3_pkg::CLAUSE_W-1:0] mem [MAX_CLAUSES];
  logic [sat3_pkg::CLAUSE_W-1:0] rd_data_r;
  logic [CW-1:0]                 count_r;
  logic                          overflow_r;
  logic [CW-1:0]                 idx_r;
  logic [AW-1:0]                 assign_r;
  logic [sat3_pkg::VC_W-1:0]     var_count_r;
  logic                          out_valid_r;
  sat3_pkg::status_t             status_r;
  sat3_pkg::status_t             out_status_r;
  logic [AW-1:0]                 last_assign;
  logic [2:0]                    lit_true;

  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < MaxCl)) begin
      mem[count_r[AD-1:0]] <= in_clause;
    end
    rd_data_r <= mem[idx_r[AD-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      overflow_r  <= 1'b0;
      var_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) var_count_r <= cfg_wdata;
      if (cmd.emit) begin
        count_r    <= '0;
        overflow_r <= 1'b0;
      end else if (cmd.load) begin
        if (count_r < MaxCl) count_r <= count_r + CW'(1);
        else                 overflow_r <= 1'b1;
      end
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_search) begin
      idx_r    <= '0;
      assign_r <= '0;
    end else if (cmd.next_clause) begin
      idx_r <= idx_r + CW'(1);
    end else if (cmd.next_assign) begin
      idx_r    <= '0;
      assign_r <= assign_r + AW'(1);
    end
    if (cmd.set_status) status_r <= cmd.status;
    if (cmd.emit) out_status_r <= status_r;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat3_pkg::lit_t d;
      logic [AW-1:0]  sh;
      d  = sat3_pkg::lit_decode(rd_data_r[k*sat3_pkg::LIT_W +: sat3_pkg::LIT_W],
                                var_count_r);
      sh = assign_r >> d.idx;
      lit_true[k] = d.hit & (sh[0] ^ d.neg);
    end
  end

  assign last_assign = {AW{1'b1}} >> (6'(AW) - {1'b0, var_count_r});

  assign sts.overflow    = overflow_r;
  assign sts.vars_bad    = var_count_r > MaxVarW;
  assign sts.empty       = count_r == '0;
  assign sts.clause_true = |lit_true;
  assign sts.last_clause = (idx_r + CW'(1)) == count_r;
  assign sts.last_assign = assign_r == last_assign;
  assign sts.out_busy    = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxCl) else $error("clause count above store depth");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == '0) && !overflow_r) else $error("store not emptied after solve");
  a_ovf_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(overflow_r) |-> $past(count_r) == MaxCl) else $error("overflow set below full");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy) else $error("result overwritten while pending");
`endif

endmodule

// ===== src/three_sat_brute_force_solver.sv =====
// Brute-force 3-SAT solver. A solve tests each clause with a memory read (S_FETCH),
// then an evaluate (S_CHECK), over assignments 0..2^var_count-1, stopping at the
// first satisfying one. Overflow, unsupported count and empty formula answer without
// a search. Every answer waits in S_DONE while an earlier status beat waits on
// out_tready. Synchronous active-low reset clears the controller, clause count, flags
// and var_count; the clause memory, search counters and status registers are not cleared.
module three_sat_brute_force_solver #(
  parameter int MAX_VARS    = sat3_pkg::MAX_VARS_DEF,
  parameter int MAX_CLAUSES = sat3_pkg::MAX_CLAUSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sat3_pkg::VC_W-1:0]          cfg_wdata,    // var_count
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sat3_pkg::IN_TDATA_W-1:0]    in_tdata,     // literal_a, literal_b, literal_c
  input  logic                               in_tuser,     // operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sat3_pkg::OUT_TDATA_W-1:0]   out_tdata     // status
);

  sat3_pkg::cmd_t              cmd;
  sat3_pkg::sts_t              sts;
  logic [sat3_pkg::STATUS_W-1:0] status;

  sat3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  sat3_dp #(
    .MAX_VARS    (MAX_VARS),
    .MAX_CLAUSES (MAX_CLAUSES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_clause  (in_tdata[sat3_pkg::CLAUSE_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (status)
  );

  assign out_tdata = {{(sat3_pkg::OUT_TDATA_W - sat3_pkg::STATUS_W){1'b0}}, status};

endmodule
